FILE: hdl/assert_macros.svh
// Assertion macros shared by the conversion block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: hdl/itoa_pkg.sv
// Types, constants and the control store of the radix conversion block.
package itoa_pkg;

  // Field widths of the stream ports.
  localparam int VALUE_W   = 32;
  localparam int BASE_W    = 6;
  localparam int S_TDATA_W = 40;
  localparam int CHAR_W    = 8;

  // Base limits and the only base that shows a sign.
  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
  localparam logic [BASE_W-1:0] BASE_TEN = 6'd10;
  localparam logic [BASE_W-1:0] DIGIT_MAX = 6'd9;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Datapath actions selected by the control word.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DIV_START,
    ACT_DIV_STEP,
    ACT_STORE,
    ACT_SET_PTR,
    ACT_EMIT_SIGN,
    ACT_EMIT_DIGIT,
    ACT_DEC_PTR,
    ACT_EMIT_ZERO
  } act_t;

  // Jump conditions tested by the sequencer.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_FIRE,
    COND_Q_ZERO,
    COND_DIV_DONE,
    COND_SLOT_FREE,
    COND_SIGN_DONE,
    COND_PTR_ZERO
  } cond_t;

  typedef logic [3:0] step_t;

  // Program addresses.
  localparam step_t STEP_IDLE      = 4'd0;
  localparam step_t STEP_ZERO_CHK  = 4'd1;
  localparam step_t STEP_DIV_START = 4'd2;
  localparam step_t STEP_DIV_LOOP  = 4'd3;
  localparam step_t STEP_STORE     = 4'd4;
  localparam step_t STEP_SET_PTR   = 4'd5;
  localparam step_t STEP_SIGN      = 4'd6;
  localparam step_t STEP_DIGIT     = 4'd7;
  localparam step_t STEP_FETCH     = 4'd8;
  localparam step_t STEP_ZERO_OUT  = 4'd9;
  localparam step_t STEP_DEC       = 4'd10;
  localparam step_t STEP_LAST      = STEP_DEC;

  // One control word: an action, a condition and both successors.
  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t jump_to;
    step_t else_to;
  } uword_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic in_fire;
    logic q_zero;
    logic div_done;
    logic slot_free;
    logic neg;
    logic ptr_zero;
  } dp_status_t;

  // Control store.
  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    w = '{act: ACT_NONE, cond: COND_ALWAYS, jump_to: STEP_IDLE, else_to: STEP_IDLE};
    case (s)
      STEP_IDLE:      w = '{ACT_LOAD,       COND_IN_FIRE,   STEP_ZERO_CHK,  STEP_IDLE};
      STEP_ZERO_CHK:  w = '{ACT_NONE,       COND_Q_ZERO,    STEP_ZERO_OUT,  STEP_DIV_START};
      STEP_DIV_START: w = '{ACT_DIV_START,  COND_ALWAYS,    STEP_DIV_LOOP,  STEP_DIV_LOOP};
      STEP_DIV_LOOP:  w = '{ACT_DIV_STEP,   COND_DIV_DONE,  STEP_STORE,     STEP_DIV_LOOP};
      STEP_STORE:     w = '{ACT_STORE,      COND_Q_ZERO,    STEP_SET_PTR,   STEP_DIV_START};
      STEP_SET_PTR:   w = '{ACT_SET_PTR,    COND_ALWAYS,    STEP_SIGN,      STEP_SIGN};
      STEP_SIGN:      w = '{ACT_EMIT_SIGN,  COND_SIGN_DONE, STEP_DIGIT,     STEP_SIGN};
      STEP_DIGIT:     w = '{ACT_EMIT_DIGIT, COND_SLOT_FREE, STEP_DEC,       STEP_DIGIT};
      STEP_FETCH:     w = '{ACT_NONE,       COND_ALWAYS,    STEP_DIGIT,     STEP_DIGIT};
      STEP_ZERO_OUT:  w = '{ACT_EMIT_ZERO,  COND_SLOT_FREE, STEP_IDLE,      STEP_ZERO_OUT};
      STEP_DEC:       w = '{ACT_DEC_PTR,    COND_PTR_ZERO,  STEP_IDLE,      STEP_FETCH};
      default:        w = '{ACT_NONE,       COND_ALWAYS,    STEP_IDLE,      STEP_IDLE};
    endcase
    return w;
  endfunction

  // Digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_MAX) begin
      c = CHAR_A + CHAR_W'(d) - CHAR_W'(BASE_TEN);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

FILE: hdl/itoa_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`include "assert_macros.svh"
module itoa_seq
  import itoa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t stat,
  output uword_t     ctrl
);

  step_t step;
  step_t step_next;
  logic  taken;

  // Current control word.
  assign ctrl = ucode_rom(step);

  // Evaluate the jump condition of this step.
  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:    taken = 1'b1;
      COND_IN_FIRE:   taken = stat.in_fire;
      COND_Q_ZERO:    taken = stat.q_zero;
      COND_DIV_DONE:  taken = stat.div_done;
      COND_SLOT_FREE: taken = stat.slot_free;
      COND_SIGN_DONE: taken = !stat.neg || stat.slot_free;
      COND_PTR_ZERO:  taken = stat.ptr_zero;
      default:        taken = 1'b1;
    endcase
    step_next = taken ? ctrl.jump_to : ctrl.else_to;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // The program counter never leaves the control store.
  `ASSERT_PROP(a_step_in_rom, clk, rst, step <= STEP_LAST)
  // A new request is taken only from the idle step.
  `ASSERT_PROP(a_load_from_idle, clk, rst, stat.in_fire |=> (step == STEP_ZERO_CHK))

endmodule

FILE: hdl/itoa_dp.sv
// Datapath: bit-serial divider, digit store and output register.
`include "assert_macros.svh"
module itoa_dp
  import itoa_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  uword_t               ctrl,
  output dp_status_t           stat,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [CHAR_W-1:0]    m_tdata,
  output logic                 m_tlast
);

  localparam int AW = $clog2(WORD_BITS);
  localparam int CW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] q;
  logic [BASE_W-1:0]    r;
  logic [BASE_W-1:0]    base_c;
  logic                 neg;
  logic [CW-1:0]        count;
  logic [AW-1:0]        bitcnt;
  logic [AW-1:0]        rdptr;
  logic [BASE_W-1:0]    rdata;
  logic [BASE_W-1:0]    store [WORD_BITS];

  logic [WORD_BITS-1:0] value_w;
  logic [BASE_W-1:0]    base_in;
  logic [BASE_W-1:0]    base_cl;
  logic                 neg_in;
  logic [BASE_W:0]      r_sh;
  logic [BASE_W:0]      r_dif;
  logic                 ge;
  logic [BASE_W-1:0]    r_next;
  logic                 in_fire;
  logic                 slot_free;
  logic                 emit;
  logic [CHAR_W-1:0]    char_next;
  logic                 last_next;

  // Input handshake and unpacking; the base is clamped into its legal range.
  // No request is taken while reset is held.
  assign s_tready = !rst && (ctrl.act == ACT_LOAD);
  assign in_fire  = s_tvalid && s_tready;
  assign value_w  = WORD_BITS'(s_tdata[VALUE_W-1:0]);
  assign base_in  = s_tdata[VALUE_W +: BASE_W];

  always_comb begin
    if (base_in < BASE_MIN) begin
      base_cl = BASE_MIN;
    end else if (base_in > BASE_MAX) begin
      base_cl = BASE_MAX;
    end else begin
      base_cl = base_in;
    end
  end

  assign neg_in = s_tuser && (base_cl == BASE_TEN) && value_w[WORD_BITS-1];

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign r_sh   = {r, q[WORD_BITS-1]};
  assign r_dif  = r_sh - {1'b0, base_c};
  assign ge     = (r_sh >= {1'b0, base_c});
  assign r_next = ge ? r_dif[BASE_W-1:0] : r_sh[BASE_W-1:0];

  // Working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      q      <= '0;
      r      <= '0;
      base_c <= BASE_MIN;
      neg    <= 1'b0;
      count  <= '0;
      bitcnt <= '0;
      rdptr  <= '0;
    end else begin
      case (ctrl.act)
        ACT_LOAD: begin
          if (in_fire) begin
            base_c <= base_cl;
            neg    <= neg_in;
            q      <= neg_in ? (WORD_BITS'(0) - value_w) : value_w;
            count  <= '0;
          end
        end
        ACT_DIV_START: begin
          r      <= '0;
          bitcnt <= '0;
        end
        ACT_DIV_STEP: begin
          r      <= r_next;
          q      <= {q[WORD_BITS-2:0], ge};
          bitcnt <= bitcnt + AW'(1);
        end
        ACT_STORE:   count <= count + CW'(1);
        ACT_SET_PTR: rdptr <= AW'(count - CW'(1));
        ACT_DEC_PTR: rdptr <= rdptr - AW'(1);
        default: ;
      endcase
    end
  end

  // Digit store, remainders least significant first.
  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_STORE) begin
      store[count[AW-1:0]] <= r;
    end
    rdata <= store[rdptr];
  end

  // Character selection for the output register.
  assign slot_free = !m_tvalid || m_tready;

  always_comb begin
    emit      = 1'b0;
    char_next = CHAR_ZERO;
    last_next = 1'b1;
    case (ctrl.act)
      ACT_EMIT_SIGN: begin
        emit      = slot_free && neg;
        char_next = CHAR_MINUS;
        last_next = 1'b0;
      end
      ACT_EMIT_DIGIT: begin
        emit      = slot_free;
        char_next = digit_char(rdata);
        last_next = (rdptr == '0);
      end
      ACT_EMIT_ZERO: begin
        emit      = slot_free;
      end
      default: ;
    endcase
  end

  // Output register: the valid flag is control, the character is payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= char_next;
      m_tlast <= last_next;
    end
  end

  // Status back to the sequencer.
  assign stat.in_fire   = in_fire;
  assign stat.q_zero    = (q == '0);
  assign stat.div_done  = (bitcnt == AW'(WORD_BITS - 1));
  assign stat.slot_free = slot_free;
  assign stat.neg       = neg;
  assign stat.ptr_zero  = (rdptr == '0);

  // A finished division leaves a remainder below the base.
  `ASSERT_PROP(a_rem_below_base, clk, rst, (ctrl.act == ACT_STORE) |-> (r < base_c))
  // The digit count never passes the store depth.
  `ASSERT_NEVER(a_count_bound, clk, rst, count > CW'(WORD_BITS))
  // A minus sign is only ever produced for base ten.
  `ASSERT_PROP(a_sign_base_ten, clk, rst,
    (emit && (ctrl.act == ACT_EMIT_SIGN)) |-> (base_c == BASE_TEN))

endmodule

FILE: hdl/integer_to_ascii_radix_core.sv
// Top level of the integer to ASCII radix conversion block.
// Converts one word per request to its ASCII digits in base 2 to 36 (out-of-range
// bases are clamped), most significant digit first, with a leading minus sign
// only for negative signed values in base ten; zero gives a single '0' and the
// final character carries tlast. Each digit costs one pass of a bit-serial
// restoring divider, and each character leaves through a one-entry output
// register. The next request is taken once the last character has been handed
// to the output register.
module integer_to_ascii_radix_core
  import itoa_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // value[31:0], base[37:32], zero pad
  input  logic                 s_tuser,  // mode: 0 unsigned, 1 signed
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [CHAR_W-1:0]    m_tdata,  // character[7:0]
  output logic                 m_tlast
);

  uword_t     ctrl;
  dp_status_t stat;

  // Program sequencer.
  itoa_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Divider, digit store and output stage.
  itoa_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .stat     (stat),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
